>>> rtl/core/uta_pkg.sv
`default_nettype none

package uta_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int DEF_MAX_DIGITS  = 64;

  localparam logic [2:0] MODE_DEC       = 3'd0;
  localparam logic [2:0] MODE_HEX_LOWER = 3'd1;
  localparam logic [2:0] MODE_HEX_UPPER = 3'd2;
  localparam logic [2:0] MODE_OCT       = 3'd3;
  localparam logic [2:0] MODE_BIN       = 3'd4;

  localparam logic [6:0] ASCII_ZERO       = 7'd48;
  localparam logic [6:0] HEX_LOWER_OFFSET = 7'd87;
  localparam logic [6:0] HEX_UPPER_OFFSET = 7'd55;
  localparam logic [4:0] DEC_BASE         = 5'd10;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       pow2;
    logic [2:0] shift;
    logic       upper;
  } cls_t;

endpackage

`default_nettype wire

>>> rtl/core/uta_front.sv
`default_nettype none

module uta_front #(
  parameter int VALUE_WIDTH = uta_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire uta_pkg::in_item_t      in_item,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output logic [VALUE_WIDTH-1:0]      job_value,
  output uta_pkg::cls_t               job_cls
);

  import uta_pkg::*;

  logic                   cls_ok;
  cls_t                   cls;
  logic                   push;
  logic                   pop;

  logic [VALUE_WIDTH-1:0] q_val_r [2];
  cls_t                   q_cls_r [2];
  logic                   q_wr_r;
  logic                   q_wr_nxt;
  logic                   q_rd_r;
  logic                   q_rd_nxt;
  logic [1:0]             q_cnt_r;
  logic [1:0]             q_cnt_nxt;

  always_comb begin
    cls_ok    = 1'b1;
    cls.pow2  = 1'b1;
    cls.shift = 3'd0;
    cls.upper = 1'b0;
    unique case (in_item.mode)
      MODE_DEC: begin
        cls.pow2 = 1'b0;
      end
      MODE_HEX_LOWER: begin
        cls.shift = 3'd4;
      end
      MODE_HEX_UPPER: begin
        cls.shift = 3'd4;
        cls.upper = 1'b1;
      end
      MODE_OCT: begin
        cls.shift = 3'd3;
      end
      MODE_BIN: begin
        cls.shift = 3'd1;
      end
      default: begin
        cls_ok = 1'b0;
      end
    endcase
  end

  assign in_ready  = (q_cnt_r != 2'd2);
  assign push      = in_valid && in_ready && cls_ok;
  assign job_valid = (q_cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job_value = q_val_r[q_rd_r];
  assign job_cls   = q_cls_r[q_rd_r];

  always_comb begin
    q_wr_nxt  = push ? ~q_wr_r : q_wr_r;
    q_rd_nxt  = pop ? ~q_rd_r : q_rd_r;
    q_cnt_nxt = q_cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      q_wr_r  <= q_wr_nxt;
      q_rd_r  <= q_rd_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_val_r[q_wr_r] <= in_item.value[VALUE_WIDTH-1:0];
      q_cls_r[q_wr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uta_back.sv
`default_nettype none

module uta_back #(
  parameter int VALUE_WIDTH = uta_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = uta_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   job_valid,
  output logic                        job_ready,
  input  wire logic [VALUE_WIDTH-1:0] job_value,
  input  wire uta_pkg::cls_t          job_cls,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output uta_pkg::out_item_t          out_item
);

  import uta_pkg::*;

  localparam int CHUNK = 8;
  localparam int NCH   = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PADW  = NCH * CHUNK;
  localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CW    = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]      state_r;
  logic [1:0]      state_nxt;
  logic [PADW-1:0] work_r;
  logic [PADW-1:0] work_nxt;
  logic [3:0]      rem_r;
  logic [3:0]      rem_nxt;
  logic [CHW-1:0]  chk_r;
  logic [CHW-1:0]  chk_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CW-1:0]   ptr_r;
  logic [CW-1:0]   ptr_nxt;
  cls_t            cls_r;
  cls_t            cls_nxt;

  logic [3:0]      dec_rem;
  logic [CHUNK-1:0] dec_qbits;
  logic [PADW-1:0] dec_work;
  logic [3:0]      pow_mask;
  logic [3:0]      pow_digit;
  logic [PADW-1:0] pow_work;

  logic            finish;
  logic [PADW-1:0] quot;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [3:0]      wr_data;
  logic            issue;
  logic [CW-1:0]   ptr_dec;
  logic [AW-1:0]   rd_addr;
  logic [2:0]      occ;

  logic [3:0]      mem [MAX_DIGITS];
  logic [3:0]      rd_data_r;
  logic            pend_r;
  logic            pend_last_r;
  logic            pend_upper_r;
  out_item_t       land_item;

  out_item_t       ob_r [2];
  logic            ob_head_r;
  logic            ob_head_nxt;
  logic [1:0]      ob_cnt_r;
  logic [1:0]      ob_cnt_nxt;
  logic            pop;

  // long division by ten, one byte of the dividend a cycle
  always_comb begin
    logic [4:0] trial;
    logic [3:0] r;
    r         = rem_r;
    dec_qbits = '0;
    for (int i = 0; i < CHUNK; i++) begin
      trial = {r, work_r[PADW-1-i]};
      if (trial >= DEC_BASE) begin
        dec_qbits[CHUNK-1-i] = 1'b1;
        r = 4'(trial - DEC_BASE);
      end else begin
        r = trial[3:0];
      end
    end
    dec_rem = r;
  end

  assign dec_work  = (work_r << CHUNK) | PADW'(dec_qbits);
  assign pow_mask  = 4'((5'd1 << cls_r.shift) - 5'd1);
  assign pow_digit = work_r[3:0] & pow_mask;
  assign pow_work  = work_r >> cls_r.shift;

  assign ptr_dec = ptr_r - CW'(1);
  assign rd_addr = ptr_dec[AW-1:0];
  assign wr_addr = count_r[AW-1:0];
  assign pop     = out_valid && out_ready;
  assign occ     = {1'b0, ob_cnt_r} - {2'b0, pop} + {2'b0, pend_r};

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    chk_nxt   = chk_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    cls_nxt   = cls_r;
    job_ready = 1'b0;
    wr_en     = 1'b0;
    wr_data   = 4'd0;
    finish    = 1'b0;
    quot      = work_r;
    issue     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          work_nxt  = PADW'(job_value);
          cls_nxt   = job_cls;
          count_nxt = '0;
          chk_nxt   = '0;
          rem_nxt   = 4'd0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (cls_r.pow2) begin
          wr_en   = 1'b1;
          wr_data = pow_digit;
          quot    = pow_work;
          finish  = 1'b1;
        end else if (chk_r == CHW'(NCH - 1)) begin
          wr_en   = 1'b1;
          wr_data = dec_rem;
          quot    = dec_work;
          finish  = 1'b1;
          chk_nxt = '0;
          rem_nxt = 4'd0;
        end else begin
          chk_nxt  = chk_r + CHW'(1);
          rem_nxt  = dec_rem;
          work_nxt = dec_work;
        end
        if (finish) begin
          count_nxt = count_r + CW'(1);
          work_nxt  = quot;
          if ((quot == '0) || (count_nxt == CW'(MAX_DIGITS))) begin
            ptr_nxt   = count_nxt;
            state_nxt = B_EMIT;
          end
        end
      end
      B_EMIT: begin
        issue = (ptr_r != '0) && (occ < 3'd2);
        if (issue) begin
          ptr_nxt = ptr_dec;
          if (ptr_r == CW'(1)) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      chk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    cls_r  <= cls_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r    <= mem[rd_addr];
      pend_last_r  <= (ptr_r == CW'(1));
      pend_upper_r <= cls_r.upper;
    end
  end

  always_comb begin
    land_item.last = pend_last_r;
    if (rd_data_r < 4'd10) begin
      land_item.character = 7'(rd_data_r) + ASCII_ZERO;
    end else if (pend_upper_r) begin
      land_item.character = 7'(rd_data_r) + HEX_UPPER_OFFSET;
    end else begin
      land_item.character = 7'(rd_data_r) + HEX_LOWER_OFFSET;
    end
  end

  assign out_valid   = (ob_cnt_r != 2'd0);
  assign out_item    = ob_r[ob_head_r];
  assign ob_head_nxt = pop ? ~ob_head_r : ob_head_r;
  assign ob_cnt_nxt  = ob_cnt_r + {1'b0, pend_r} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      ob_head_r <= 1'b0;
      ob_cnt_r  <= 2'd0;
    end else begin
      pend_r    <= issue;
      ob_head_r <= ob_head_nxt;
      ob_cnt_r  <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      ob_r[ob_head_r ^ ob_cnt_r[0]] <= land_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/unsigned_to_ascii_radix.sv
// Converts an unsigned value to its ASCII digits in decimal, lower or upper case
// hex, octal or binary, most significant digit first, one character per output
// request, with last set on the final one; an unused mode is accepted and dropped.
// Hex, octal and binary digits are split off the low bits by a shift; decimal
// digits come from a long division by ten that works one byte of the dividend
// at a time. The digits then leave at one per cycle, while the output accepts
// them, through the single read port of the digit store; each is read into a
// register and then passes a two-entry output buffer. A two-deep queue takes
// up to two further requests while one is being converted.
`default_nettype none

module unsigned_to_ascii_radix #(
  parameter int VALUE_WIDTH = uta_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = uta_pkg::DEF_MAX_DIGITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire uta_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output uta_pkg::out_item_t      out_item
);

  import uta_pkg::*;

  logic                   job_valid;
  logic                   job_ready;
  logic [VALUE_WIDTH-1:0] job_value;
  cls_t                   job_cls;

  uta_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_value (job_value),
    .job_cls   (job_cls)
  );

  uta_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_value (job_value),
    .job_cls   (job_cls),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/core/uta_checker.sv
`default_nettype none

module uta_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire uta_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire uta_pkg::out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input request changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("output request changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.character >= 7'd48 && out_item.character <= 7'd57)
               || (out_item.character >= 7'd65 && out_item.character <= 7'd70)
               || (out_item.character >= 7'd97 && out_item.character <= 7'd102))
    else $error("character is not a digit");

endmodule

bind unsigned_to_ascii_radix uta_checker u_uta_checker (.*);

`default_nettype wire
